// File: hw/rtl/rthc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rthc_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned HueW  = 15;
  localparam int unsigned SatW  = 16;
  localparam int unsigned QuoW  = 16;
  localparam int unsigned DivdW = 23;
  localparam int unsigned InTdataW  = 24;
  localparam int unsigned OutTdataW = 40;

  // one restoring division in flight: remainder, dividend bits still to
  // shift in (quotient bits fill in from the bottom), divisor
  typedef struct packed {
    logic [PixW-1:0] rem;
    logic [QuoW-1:0] work;
    logic [PixW-1:0] div;
  } rthc_lane_t;

  typedef struct packed {
    rthc_lane_t      hue;
    rthc_lane_t      sat;
    logic            gray;
    logic            black;
    logic [PixW-1:0] value;
  } rthc_pkt_t;

  function automatic rthc_lane_t rthc_div_step(rthc_lane_t l);
    logic [PixW:0] t;
    logic [PixW:0] d;
    logic          ge;
    rthc_lane_t    o;
    t  = {l.rem, l.work[QuoW-1]};
    d  = {1'b0, l.div};
    ge = (t >= d);
    o.rem  = ge ? PixW'(t - d) : t[PixW-1:0];
    o.work = {l.work[QuoW-2:0], ge};
    o.div  = l.div;
    return o;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/rthc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rthc_front
  import rthc_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [PixW-1:0] red_i,
  input  wire logic [PixW-1:0] green_i,
  input  wire logic [PixW-1:0] blue_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output rthc_pkt_t            out_pkt_o
);

  logic            valid_q;
  rthc_pkt_t       pkt_q, pkt_d;
  logic [PixW-1:0] v, mn, c;
  logic signed [11:0] total;
  logic signed [11:0] cs, rs, gs, bs;
  logic [10:0]      tot_u;
  logic [DivdW-1:0] hue_dvd, sat_dvd;

  always_comb begin
    v = red_i;
    if (green_i > v) v = green_i;
    if (blue_i > v) v = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    c  = v - mn;
    cs = signed'({4'd0, c});
    rs = signed'({4'd0, red_i});
    gs = signed'({4'd0, green_i});
    bs = signed'({4'd0, blue_i});
    if (red_i == v && green_i >= blue_i) begin
      total = gs - bs;
    end else if (red_i == v) begin
      total = 12'(cs * 6) + gs - bs;
    end else if (green_i == v) begin
      total = (cs <<< 1) + bs - rs;
    end else begin
      total = (cs <<< 2) + rs - gs;
    end
    tot_u   = total[10:0];
    // 3840 * total
    hue_dvd = ({tot_u, 12'd0} - {4'd0, tot_u, 8'd0});
    sat_dvd = {c, 15'd0};

    pkt_d.hue.rem  = {1'b0, hue_dvd[DivdW-1:QuoW]};
    pkt_d.hue.work = hue_dvd[QuoW-1:0];
    pkt_d.hue.div  = c;
    pkt_d.sat.rem  = {1'b0, sat_dvd[DivdW-1:QuoW]};
    pkt_d.sat.work = sat_dvd[QuoW-1:0];
    pkt_d.sat.div  = v;
    pkt_d.gray     = (c == '0);
    pkt_d.black    = (v == '0);
    pkt_d.value    = v;
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_pkt_o   = pkt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      pkt_q <= pkt_d;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rthc_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module rthc_div_cell
  import rthc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire rthc_pkt_t in_pkt_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output rthc_pkt_t      out_pkt_o
);

  logic      valid_q;
  rthc_pkt_t pkt_q, pkt_d;

  always_comb begin
    pkt_d     = in_pkt_i;
    pkt_d.hue = rthc_div_step(in_pkt_i.hue);
    pkt_d.sat = rthc_div_step(in_pkt_i.sat);
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_pkt_o   = pkt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      pkt_q <= pkt_d;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rgb_to_hsv_converter.sv
// RGB to HSV pixel converter.
// Slave channel s_axis_*: one RGB pixel per beat, accepted when tvalid and
// tready are both high. Master channel m_axis_*: one hue/saturation/value
// beat per pixel, in input order.
// Hue is in 1/64 degree (0..23039, 0 for gray), saturation in 1/32768
// (0 for black), value is the largest channel byte.
// The datapath has one stage that finds max/min/sector, then 16 cells that
// each retire one quotient bit of both the hue and the saturation division.
// Throughput: one pixel per cycle unless the receiver stalls; one quotient bit per cell.
// Every stage is an elastic register: when the receiver stalls, beats pile
// up into empty stages and the input keeps being taken until the chain is
// full; then tready falls and everything holds.
// Reset clears all stage valid flags; no output beat is pending after it.
`timescale 1ns / 1ps
`default_nettype none
module rgb_to_hsv_converter
  import rthc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // red[7:0], green[15:8], blue[23:16]
  input  wire logic [InTdataW-1:0]  s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // hue[14:0], saturation[30:15], brightness[38:31], zero[39]
  output logic [OutTdataW-1:0]      m_axis_tdata_o
);

  logic      valid  [QuoW+1];
  logic      ready  [QuoW+1];
  rthc_pkt_t pkt    [QuoW+1];
  logic [HueW-1:0] hue;
  logic [SatW-1:0] sat;

  rthc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .red_i       (s_axis_tdata_i[7:0]),
    .green_i     (s_axis_tdata_i[15:8]),
    .blue_i      (s_axis_tdata_i[23:16]),
    .out_valid_o (valid[0]),
    .out_ready_i (ready[0]),
    .out_pkt_o   (pkt[0])
  );

  for (genvar i = 0; i < QuoW; i++) begin : g_cells
    rthc_div_cell u_div_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid[i]),
      .in_ready_o  (ready[i]),
      .in_pkt_i    (pkt[i]),
      .out_valid_o (valid[i+1]),
      .out_ready_i (ready[i+1]),
      .out_pkt_o   (pkt[i+1])
    );
  end

  assign ready[QuoW] = m_axis_tready_i;

  assign hue = pkt[QuoW].gray  ? '0 : pkt[QuoW].hue.work[HueW-1:0];
  assign sat = pkt[QuoW].black ? '0 : pkt[QuoW].sat.work;

  assign m_axis_tvalid_o = valid[QuoW];
  assign m_axis_tdata_o  = {1'b0, pkt[QuoW].value, sat, hue};

endmodule
`default_nettype wire

// File: test/rgb_to_hsv_converter_tb.sv
`timescale 1ns / 1ps
module rgb_to_hsv_converter_tb;
  import rthc_pkg::*;

  localparam int DirRows    = 24;
  localparam int RandPerMix = 300;
  localparam int Latency    = 17;
  localparam int CycleLimit = 100000;
  localparam int HueSector  = 3840;
  localparam int SatOne     = 32768;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [SatW-1:0] sat;
    logic [PixW-1:0] val;
  } hsv_t;

  typedef struct packed {
    logic [PixW-1:0] r;
    logic [PixW-1:0] g;
    logic [PixW-1:0] b;
    logic            known;
    logic [HueW-1:0] hue;
    logic [SatW-1:0] sat;
    logic [PixW-1:0] val;
  } pixel_row_t;

  // known = 1: hsv typed in; otherwise taken from the predictor
  localparam pixel_row_t PixelTable [DirRows] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, 15'd0,     16'd0,     8'd0},
    '{8'd255, 8'd255, 8'd255, 1'b1, 15'd0,     16'd0,     8'd255},
    '{8'd128, 8'd128, 8'd128, 1'b1, 15'd0,     16'd0,     8'd128},
    '{8'd1,   8'd1,   8'd1,   1'b1, 15'd0,     16'd0,     8'd1},
    '{8'd255, 8'd0,   8'd0,   1'b1, 15'd0,     16'd32768, 8'd255},
    '{8'd0,   8'd255, 8'd0,   1'b1, 15'd7680,  16'd32768, 8'd255},
    '{8'd0,   8'd0,   8'd255, 1'b1, 15'd15360, 16'd32768, 8'd255},
    '{8'd255, 8'd255, 8'd0,   1'b1, 15'd3840,  16'd32768, 8'd255},
    '{8'd0,   8'd255, 8'd255, 1'b1, 15'd11520, 16'd32768, 8'd255},
    '{8'd255, 8'd0,   8'd255, 1'b1, 15'd19200, 16'd32768, 8'd255},
    '{8'd1,   8'd0,   8'd0,   1'b1, 15'd0,     16'd32768, 8'd1},
    '{8'd0,   8'd1,   8'd0,   1'b1, 15'd7680,  16'd32768, 8'd1},
    '{8'd0,   8'd0,   8'd1,   1'b1, 15'd15360, 16'd32768, 8'd1},
    '{8'd255, 8'd0,   8'd1,   1'b0, 15'd0,     16'd0,     8'd0},
    '{8'd255, 8'd1,   8'd0,   1'b0, 15'd0,     16'd0,     8'd0},
    '{8'd254, 8'd255, 8'd255, 1'b0, 15'd0,     16'd0,     8'd0},
    '{8'd255, 8'd254, 8'd255, 1'b0, 15'd0,     16'd0,     8'd0},
    '{8'd255, 8'd255, 8'd254, 1'b0, 15'd0,     16'd0,     8'd0},
    '{8'd255, 8'd254, 8'd254, 1'b0, 15'd0,     16'd0,     8'd0},
    '{8'd1,   8'd0,   8'd1,   1'b0, 15'd0,     16'd0,     8'd0},
    '{8'd128, 8'd64,  8'd32,  1'b0, 15'd0,     16'd0,     8'd0},
    '{8'd17,  8'd200, 8'd99,  1'b0, 15'd0,     16'd0,     8'd0},
    '{8'd99,  8'd17,  8'd200, 1'b0, 15'd0,     16'd0,     8'd0},
    '{8'd200, 8'd99,  8'd17,  1'b0, 15'd0,     16'd0,     8'd0}
  };

  logic                 clk_i   = 1'b0;
  logic                 rst_ni  = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [InTdataW-1:0]  s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OutTdataW-1:0] m_tdata;

  hsv_t hsv_expected_q[$];
  hsv_t want_hsv;
  hsv_t got_hsv;
  int   send_idle_pct  = 18;
  int   recv_stall_pct = 54;
  int   err_cnt        = 0;
  int   pixels_sent    = 0;
  int   beats_checked  = 0;
  int   cycle_cnt      = 0;

  rgb_to_hsv_converter u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic hsv_t predict_hsv(input logic [PixW-1:0] r, g, b);
    int   ri, gi, bi, vmax, vmin, chroma, total;
    hsv_t p;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    vmax = ri;
    if (gi > vmax) vmax = gi;
    if (bi > vmax) vmax = bi;
    vmin = ri;
    if (gi < vmin) vmin = gi;
    if (bi < vmin) vmin = bi;
    chroma = vmax - vmin;
    p.hue = '0;
    if (chroma != 0) begin
      // sector order sets tie-breaking: red, then green, then blue
      if (ri == vmax && gi >= bi) begin
        total = gi - bi;
      end else if (ri == vmax) begin
        total = 6 * chroma + gi - bi;
      end else if (gi == vmax) begin
        total = 2 * chroma + bi - ri;
      end else begin
        total = 4 * chroma + ri - gi;
      end
      p.hue = HueW'((HueSector * total) / chroma);
    end
    p.sat = (vmax != 0) ? SatW'((SatOne * chroma) / vmax) : '0;
    p.val = PixW'(vmax);
    return p;
  endfunction

  task automatic note_failure(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic send_pixel(input logic [PixW-1:0] r, g, b, input hsv_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, g, r};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    hsv_expected_q.push_back(want);
    pixels_sent++;
  endtask

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt,
               hsv_expected_q.size());
      $display("rgb_to_hsv_converter_tb: FAIL");
      $finish;
    end
  end

  // output beat: hue[14:0], saturation[30:15], brightness[38:31], zero[39]
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      got_hsv = '{hue: m_tdata[14:0], sat: m_tdata[30:15], val: m_tdata[38:31]};
      if (hsv_expected_q.size() == 0) begin
        note_failure($sformatf("unexpected beat h=%0d s=%0d v=%0d",
                               got_hsv.hue, got_hsv.sat, got_hsv.val));
      end else begin
        want_hsv = hsv_expected_q.pop_front();
        beats_checked++;
        if (got_hsv !== want_hsv || m_tdata[39] !== 1'b0) begin
          note_failure($sformatf("beat %0d exp h=%0d s=%0d v=%0d got h=%0d s=%0d v=%0d z=%b",
                                 beats_checked, want_hsv.hue, want_hsv.sat, want_hsv.val,
                                 got_hsv.hue, got_hsv.sat, got_hsv.val, m_tdata[39]));
        end
      end
    end
  end

  initial begin
    logic [PixW-1:0] r, g, b, top, other;
    int              base;
    hsv_t            row_hsv;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int mix = 0; mix < 3; mix++) begin
      case (mix)
        0: begin
          send_idle_pct  = 18;
          recv_stall_pct = 54;
        end
        1: begin
          send_idle_pct  = 54;
          recv_stall_pct = 18;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase

      if (mix == 0) begin
        for (int i = 0; i < DirRows; i++) begin
          row_hsv = '{hue: PixelTable[i].hue, sat: PixelTable[i].sat,
                      val: PixelTable[i].val};
          send_pixel(PixelTable[i].r, PixelTable[i].g, PixelTable[i].b,
                     PixelTable[i].known ? row_hsv :
                     predict_hsv(PixelTable[i].r, PixelTable[i].g, PixelTable[i].b));
        end
      end

      for (int n = 0; n < RandPerMix; n++) begin
        r = PixW'($urandom);
        g = PixW'($urandom);
        b = PixW'($urandom);
        case ($urandom_range(9))
          5: begin
            g = r;
            b = r;
          end
          6: begin
            // two channels tie for the maximum
            top   = PixW'($urandom_range(255));
            other = PixW'($urandom_range(top));
            case ($urandom_range(2))
              0: {r, g, b} = {top, top, other};
              1: {r, g, b} = {top, other, top};
              default: {r, g, b} = {other, top, top};
            endcase
          end
          7: begin
            r = $urandom_range(1) ? 8'hFF : 8'h00;
            g = $urandom_range(1) ? 8'hFF : 8'h00;
            b = $urandom_range(1) ? 8'hFF : 8'h00;
          end
          8: begin
            // near gray: small chroma stresses the dividers
            base = $urandom_range(253, 2);
            r = PixW'(base - 2 + $urandom_range(4));
            g = PixW'(base - 2 + $urandom_range(4));
            b = PixW'(base - 2 + $urandom_range(4));
          end
          9: begin
            r = PixW'($urandom_range(3));
            g = PixW'($urandom_range(3));
            b = PixW'($urandom_range(3));
          end
          default: ;
        endcase
        send_pixel(r, g, b, predict_hsv(r, g, b));
      end
    end

    s_tvalid <= 1'b0;
    while (hsv_expected_q.size() != 0) @(posedge clk_i);
    repeat (2 * Latency) @(posedge clk_i);

    $display("converted %0d pixels (%0d table rows), %0d beats checked", pixels_sent,
             DirRows, beats_checked);
    $display("covered gray, black, channel ties, extremes and near-gray under three stall mixes");
    if (err_cnt == 0) begin
      $display("rgb_to_hsv_converter_tb: PASS");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("rgb_to_hsv_converter_tb: FAIL");
    end
    $finish;
  end

endmodule
